@@ rtl/kmeans_clustering_engine_unit_defines.svh @@
// Assertion macros shared by the checker of the clustering engine.
`ifndef KMEANS_CLUSTERING_ENGINE_UNIT_DEFINES_SVH
`define KMEANS_CLUSTERING_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KMCE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define KMCE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/kmce_pkg.sv @@
package kmce_pkg;

   localparam int SampleDepth  = 4096;
   localparam int AddrBits     = 12;
   localparam int CountBits    = 13;
   localparam int MaxClusters  = 8;
   localparam int ClusterBits  = 3;
   localparam int Dims         = 3;
   localparam int CompBits     = 8;
   localparam int MeanBits     = 16;
   localparam int SumBits      = 20;
   localparam int SqBits       = 34;
   localparam int RootBits     = 17;
   localparam int TotalBits    = 29;
   localparam int DivisorBits  = 13;
   localparam int CostBits     = 17;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } kmce_action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FEW   = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } kmce_status_type;

   typedef enum logic [1:0] {
      CSR_CLUSTERS  = 2'd0,
      CSR_MAX_ITER  = 2'd1,
      CSR_TOLERANCE = 2'd2,
      CSR_UNUSED    = 2'd3
   } kmce_csr_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LBL, S_RESP,
      S_INIT_DIV, S_INIT_WAIT, S_INIT_RD, S_INIT_WR,
      S_ROUND, S_SMP_RD, S_MUL, S_ACC, S_SQRT_GO, S_SQRT_WAIT,
      S_COST_GO, S_COST_WAIT, S_MEAN_CHK, S_MEAN_GO, S_MEAN_WAIT,
      S_STAB_MUL, S_STAB_CHK
   } kmce_state_type;

   // Handshake between the sequencer and an iterative unit.
   typedef struct packed {
      logic start;
   } kmce_unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } kmce_unit_sts_type;

endpackage

@@ rtl/kmce_div.sv @@
// Restoring divider, one quotient bit per cycle.
module kmce_div
   import kmce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  kmce_unit_ctl_type      ctl,
   input  logic [TotalBits-1:0]   dividend,
   input  logic [DivisorBits-1:0] divisor,
   output kmce_unit_sts_type      sts,
   output logic [TotalBits-1:0]   quotient
);

   localparam int CntBits = $clog2(TotalBits + 1);

   logic [TotalBits-1:0]   quo_ff, quo_in;
   logic [DivisorBits-1:0] rem_ff, rem_in;
   logic [DivisorBits-1:0] dsr_ff, dsr_in;
   logic [CntBits-1:0]     cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [DivisorBits:0]   trial;

   // One shift-and-subtract step.
   always_comb begin
      trial   = {rem_ff, quo_ff[TotalBits-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CntBits'(TotalBits);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DivisorBits'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[TotalBits-2:0], 1'b1};
         end else begin
            rem_in = trial[DivisorBits-1:0];
            quo_in = {quo_ff[TotalBits-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CntBits'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/kmce_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module kmce_isqrt
   import kmce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  kmce_unit_ctl_type   ctl,
   input  logic [SqBits-1:0]   radicand,
   output kmce_unit_sts_type   sts,
   output logic [RootBits-1:0] root
);

   localparam int RemBits = RootBits + 3;
   localparam int CntBits = $clog2(RootBits + 1);

   logic [SqBits-1:0]   val_ff, val_in;
   logic [RemBits-1:0]  rem_ff, rem_in;
   logic [RootBits-1:0] root_ff, root_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [RemBits-1:0]  rem_shift;
   logic [RemBits-1:0]  trial;

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {rem_ff[RemBits-3:0], val_ff[SqBits-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      val_in    = val_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CntBits'(RootBits);
      end else if (cnt_ff != '0) begin
         val_in = {val_ff[SqBits-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[RootBits-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CntBits'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign root     = root_ff;

endmodule

@@ rtl/kmeans_clustering_engine_unit.sv @@
// A load or clear word goes from the request straight to the response, a label read first
// through a label-read state; a configuration word is taken every cycle. One request is
// in flight at a time. A run repeats rounds over all N samples and K clusters; one 16x16
// multiplier squares each component difference, a square root takes each nearest distance
// and one divider, shared with the set-up and the cost, forms the new means.
// Reset is synchronous and active high; it clears control state, counters and means.
module kmeans_clustering_engine_unit
   import kmce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [CompBits-1:0]   req_comp0,
   input  logic [CompBits-1:0]   req_comp1,
   input  logic [CompBits-1:0]   req_comp2,
   input  logic [AddrBits-1:0]   req_sample_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [2:0]            rsp_label,
   output logic [15:0]           rsp_rounds_done,
   output logic [CostBits-1:0]   rsp_average_cost,
   output logic [CountBits-1:0]  rsp_samples_held,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

   kmce_state_type state_ff, state_in;

   // Configuration registers.
   logic [3:0]  clusters_ff;
   logic [15:0] max_iter_ff;
   logic [15:0] tol_ff;

   // Stores.
   logic [Dims*CompBits-1:0] sample_mem [SampleDepth];
   logic [ClusterBits-1:0]   label_mem  [SampleDepth];
   logic [Dims*CompBits-1:0] smp_rd_ff;
   logic [ClusterBits-1:0]   lbl_rd_ff;
   logic [AddrBits-1:0]      smp_addr;

   // Cluster state.
   logic [MeanBits-1:0]  means_ff  [MaxClusters][Dims];
   logic [SumBits-1:0]   sums_ff   [MaxClusters][Dims];
   logic [CountBits-1:0] counts_ff [MaxClusters];

   logic [CountBits-1:0] count_ff;
   logic [CostBits-1:0]  prev_cost_ff;
   logic [1:0]           stable_ff;
   logic [15:0]          rounds_ff;

   // Run working registers.
   logic [3:0]             k_ff;
   logic [AddrBits-1:0]    interval_ff;
   logic [AddrBits-1:0]    init_addr_ff;
   logic [AddrBits-1:0]    i_ff;
   logic [ClusterBits-1:0] c_ff;
   logic [1:0]             d_ff;
   logic [31:0]            prod_ff;
   logic [SqBits-1:0]      acc_ff;
   logic [SqBits-1:0]      best_sq_ff;
   logic [ClusterBits-1:0] best_ff;
   logic [TotalBits-1:0]   total_ff;
   logic [CostBits-1:0]    curr_ff;
   logic [CostBits-1:0]    last_ff;
   logic [32:0]            tol_prod_ff;
   logic                   lbl_pass_ff;

   // Response word.
   logic [1:0]             status_ff;
   logic [ClusterBits-1:0] label_ff;

   // Shared units.
   kmce_unit_ctl_type      div_ctl, sqrt_ctl;
   kmce_unit_sts_type      div_sts, sqrt_sts;
   logic [TotalBits-1:0]   div_dividend, div_quo;
   logic [DivisorBits-1:0] div_divisor;
   logic [RootBits-1:0]    sqrt_root;

   // Decoded request and datapath helpers.
   logic                  req_fire;
   kmce_action_type       action;
   logic [3:0]            k_eff;
   logic                  c_last, dist_last, i_last;
   logic [CompBits-1:0]   comp_sel;
   logic [MeanBits-1:0]   diff;
   logic [SqBits-1:0]     sq_sum;
   logic [ClusterBits-1:0] best_pick;
   logic                  smp_we, lbl_we;
   logic [CostBits-1:0]   cost_diff;
   logic                  stable_hit;
   logic [15:0]           rounds_next;
   logic [1:0]            stable_next;
   logic                  run_end;

   assign req_fire  = req_valid && req_ready;
   assign action    = kmce_action_type'(req_action);
   assign k_eff     = (clusters_ff == 4'd0) ? 4'd1 :
                      (clusters_ff > 4'(MaxClusters)) ? 4'(MaxClusters) : clusters_ff;
   assign c_last    = ({1'b0, c_ff} == k_ff - 4'd1);
   assign dist_last = (d_ff == 2'(Dims - 1)) && c_last;
   assign i_last    = ({1'b0, i_ff} == count_ff - 1'b1);
   assign comp_sel  = smp_rd_ff[d_ff*CompBits +: CompBits];

   // Distance of one component to the current centre.
   always_comb begin
      if ({comp_sel, 8'h00} >= means_ff[c_ff][d_ff]) begin
         diff = {comp_sel, 8'h00} - means_ff[c_ff][d_ff];
      end else begin
         diff = means_ff[c_ff][d_ff] - {comp_sel, 8'h00};
      end
      sq_sum = acc_ff + SqBits'(prod_ff);
   end

   // Nearest centre including the one compared in this cycle.
   assign best_pick = (c_ff == '0 || sq_sum < best_sq_ff) ? c_ff : best_ff;

   // Stability test of the round cost.
   assign cost_diff   = (last_ff >= curr_ff) ? last_ff - curr_ff : curr_ff - last_ff;
   assign stable_hit  = ({cost_diff, 16'h0000} < tol_prod_ff);
   assign stable_next = stable_hit ? stable_ff + 2'd1 : stable_ff;
   assign rounds_next = rounds_ff + 16'd1;
   assign run_end     = (rounds_next >= max_iter_ff) || (stable_next == 2'd3);

   // Shared divider operands.
   always_comb begin
      case (state_ff)
         S_INIT_DIV: begin
            div_dividend = TotalBits'(count_ff);
            div_divisor  = DivisorBits'(k_ff);
         end
         S_COST_GO: begin
            div_dividend = total_ff;
            div_divisor  = count_ff;
         end
         default: begin
            div_dividend = TotalBits'({sums_ff[c_ff][d_ff], 8'h00});
            div_divisor  = counts_ff[c_ff];
         end
      endcase
   end

   kmce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   kmce_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sqrt_ctl),
      .radicand (best_sq_ff),
      .sts      (sqrt_sts),
      .root     (sqrt_root)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (action == ACT_READ) begin
                  state_in = S_LBL;
               end else if (action == ACT_RUN && count_ff >= CountBits'(k_eff)) begin
                  state_in = S_INIT_DIV;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_LBL:       state_in = S_RESP;
         S_RESP:      if (rsp_ready) state_in = S_IDLE;
         S_INIT_DIV:  state_in = S_INIT_WAIT;
         S_INIT_WAIT: if (div_sts.done) state_in = S_INIT_RD;
         S_INIT_RD:   state_in = S_INIT_WR;
         S_INIT_WR:   state_in = c_last ? S_ROUND : S_INIT_RD;
         S_ROUND:     state_in = S_SMP_RD;
         S_SMP_RD:    state_in = S_MUL;
         S_MUL:       state_in = S_ACC;
         S_ACC: begin
            if (!dist_last) begin
               state_in = S_MUL;
            end else if (lbl_pass_ff) begin
               state_in = i_last ? S_RESP : S_SMP_RD;
            end else begin
               state_in = S_SQRT_GO;
            end
         end
         S_SQRT_GO:   state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: if (sqrt_sts.done) state_in = i_last ? S_COST_GO : S_SMP_RD;
         S_COST_GO:   state_in = S_COST_WAIT;
         S_COST_WAIT: if (div_sts.done) state_in = S_MEAN_CHK;
         S_MEAN_CHK: begin
            if (counts_ff[c_ff] != '0) begin
               state_in = S_MEAN_GO;
            end else if (c_last) begin
               state_in = S_STAB_MUL;
            end
         end
         S_MEAN_GO:   state_in = S_MEAN_WAIT;
         S_MEAN_WAIT: begin
            if (div_sts.done) begin
               if (d_ff != 2'(Dims - 1)) begin
                  state_in = S_MEAN_GO;
               end else begin
                  state_in = c_last ? S_STAB_MUL : S_MEAN_CHK;
               end
            end
         end
         S_STAB_MUL:  state_in = S_STAB_CHK;
         S_STAB_CHK:  state_in = run_end ? S_SMP_RD : S_ROUND;
         default:     state_in = S_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      rsp_valid      = (state_ff == S_RESP);
      csr_ready      = 1'b1;
      div_ctl.start  = (state_ff == S_INIT_DIV) || (state_ff == S_COST_GO) ||
                       (state_ff == S_MEAN_GO);
      sqrt_ctl.start = (state_ff == S_SQRT_GO);
      smp_we         = req_fire && (action == ACT_LOAD) &&
                       (count_ff < CountBits'(SampleDepth));
      lbl_we         = (state_ff == S_ACC) && dist_last && lbl_pass_ff;
      case (state_ff)
         S_INIT_RD, S_INIT_WR: smp_addr = init_addr_ff;
         default:              smp_addr = i_ff;
      endcase
   end

   // Sample and label stores.
   always_ff @(posedge clock) begin
      if (smp_we) begin
         sample_mem[count_ff[AddrBits-1:0]] <= {req_comp2, req_comp1, req_comp0};
      end
      smp_rd_ff <= sample_mem[smp_addr];
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         label_mem[i_ff] <= best_pick;
      end
      lbl_rd_ff <= label_mem[req_sample_index];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= 4'd2;
         max_iter_ff <= 16'd1000;
         tol_ff      <= 16'd7;
      end else if (csr_valid && csr_ready) begin
         case (kmce_csr_type'(csr_index))
            CSR_CLUSTERS:  clusters_ff <= csr_data[3:0];
            CSR_MAX_ITER:  max_iter_ff <= csr_data;
            CSR_TOLERANCE: tol_ff      <= csr_data;
            default:       ;
         endcase
      end
   end

   // Sequencer state and block-level state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         prev_cost_ff <= '0;
         stable_ff    <= '0;
         rounds_ff    <= '0;
         lbl_pass_ff  <= 1'b0;
         for (int c = 0; c < MaxClusters; c++) begin
            counts_ff[c] <= '0;
            for (int d = 0; d < Dims; d++) begin
               means_ff[c][d] <= '0;
               sums_ff[c][d]  <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  status_ff <= ST_OK;
                  label_ff  <= '0;
                  case (action)
                     ACT_LOAD: begin
                        if (smp_we) begin
                           count_ff <= count_ff + 1'b1;
                        end else begin
                           status_ff <= ST_FULL;
                        end
                     end
                     ACT_RUN: begin
                        k_ff <= k_eff;
                        if (count_ff < CountBits'(k_eff)) begin
                           status_ff <= ST_FEW;
                        end
                     end
                     ACT_READ: begin
                        if ({1'b0, req_sample_index} >= count_ff) begin
                           status_ff <= ST_RANGE;
                        end
                     end
                     default: count_ff <= '0;
                  endcase
               end
            end
            S_LBL: begin
               if (status_ff == ST_OK) label_ff <= lbl_rd_ff;
            end
            S_INIT_DIV: begin
               stable_ff    <= '0;
               rounds_ff    <= '0;
               lbl_pass_ff  <= 1'b0;
               curr_ff      <= '0;
               init_addr_ff <= '0;
               c_ff         <= '0;
            end
            S_INIT_WAIT: interval_ff <= div_quo[AddrBits-1:0];
            S_INIT_WR: begin
               for (int d = 0; d < Dims; d++) begin
                  means_ff[c_ff][d] <= {smp_rd_ff[d*CompBits +: CompBits], 8'h00};
               end
               init_addr_ff <= init_addr_ff + interval_ff;
               c_ff         <= c_ff + 1'b1;
            end
            S_ROUND: begin
               last_ff  <= curr_ff;
               total_ff <= '0;
               i_ff     <= '0;
               c_ff     <= '0;
               d_ff     <= '0;
               acc_ff   <= '0;
               for (int c = 0; c < MaxClusters; c++) begin
                  counts_ff[c] <= '0;
                  for (int d = 0; d < Dims; d++) sums_ff[c][d] <= '0;
               end
            end
            S_MUL: prod_ff <= diff * diff;
            S_ACC: begin
               if (d_ff == 2'(Dims - 1)) begin
                  if (c_ff == '0 || sq_sum < best_sq_ff) begin
                     best_sq_ff <= sq_sum;
                     best_ff    <= c_ff;
                  end
                  acc_ff <= '0;
                  d_ff   <= '0;
                  if (c_last) begin
                     c_ff <= '0;
                     if (lbl_pass_ff) i_ff <= i_ff + 1'b1;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end else begin
                  acc_ff <= sq_sum;
                  d_ff   <= d_ff + 1'b1;
               end
            end
            S_SQRT_WAIT: begin
               if (sqrt_sts.done) begin
                  total_ff           <= total_ff + TotalBits'(sqrt_root);
                  counts_ff[best_ff] <= counts_ff[best_ff] + 1'b1;
                  for (int d = 0; d < Dims; d++) begin
                     sums_ff[best_ff][d] <= sums_ff[best_ff][d] +
                                            SumBits'(smp_rd_ff[d*CompBits +: CompBits]);
                  end
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_COST_WAIT: begin
               if (div_sts.done) begin
                  curr_ff <= div_quo[CostBits-1:0];
                  c_ff    <= '0;
                  d_ff    <= '0;
               end
            end
            S_MEAN_CHK: begin
               if (counts_ff[c_ff] == '0 && !c_last) c_ff <= c_ff + 1'b1;
            end
            S_MEAN_WAIT: begin
               if (div_sts.done) begin
                  means_ff[c_ff][d_ff] <= div_quo[MeanBits-1:0];
                  if (d_ff != 2'(Dims - 1)) begin
                     d_ff <= d_ff + 1'b1;
                  end else begin
                     d_ff <= '0;
                     if (!c_last) c_ff <= c_ff + 1'b1;
                  end
               end
            end
            S_STAB_MUL: tol_prod_ff <= tol_ff * last_ff;
            S_STAB_CHK: begin
               stable_ff <= stable_next;
               rounds_ff <= rounds_next;
               if (run_end) begin
                  prev_cost_ff <= curr_ff;
                  lbl_pass_ff  <= 1'b1;
                  i_ff         <= '0;
                  c_ff         <= '0;
                  d_ff         <= '0;
                  acc_ff       <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Response word.
   assign rsp_status       = status_ff;
   assign rsp_label        = label_ff;
   assign rsp_rounds_done  = rounds_ff;
   assign rsp_average_cost = prev_cost_ff;
   assign rsp_samples_held = count_ff;

endmodule

@@ rtl/kmce_checker.sv @@
`include "kmeans_clustering_engine_unit_defines.svh"

// Port-level checks of the clustering engine.
module kmce_checker
   import kmce_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [1:0]           req_action,
   input logic [CompBits-1:0]  req_comp0,
   input logic [CompBits-1:0]  req_comp1,
   input logic [CompBits-1:0]  req_comp2,
   input logic [AddrBits-1:0]  req_sample_index,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input logic [2:0]           rsp_label,
   input logic [15:0]          rsp_rounds_done,
   input logic [CostBits-1:0]  rsp_average_cost,
   input logic [CountBits-1:0] rsp_samples_held,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [1:0]           csr_index,
   input logic [15:0]          csr_data
);

   // A pending word keeps valid until taken.
   `KMCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")

   // No new request while a response waits.
   `KMCE_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, !req_ready, "ready with response pending")

   // An accepted request makes the block busy.
   `KMCE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   // A failed request carries label zero.
   `KMCE_ASSERT_NOW(a_label_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_label == 3'd0, "label on error")

endmodule

bind kmeans_clustering_engine_unit kmce_checker u_kmce_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top
   import kmce_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kmce_action_type      action;
      logic [CompBits-1:0]  comp0;
      logic [CompBits-1:0]  comp1;
      logic [CompBits-1:0]  comp2;
      logic [AddrBits-1:0]  index;
   } req_word_type;

   typedef struct packed {
      kmce_status_type      status;
      logic [2:0]           label;
      logic [15:0]          rounds;
      logic [CostBits-1:0]  cost;
      logic [CountBits-1:0] held;
   } rsp_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [2:0]           rsp_label;
   logic [15:0]          rsp_rounds_done;
   logic [CostBits-1:0]  rsp_average_cost;
   logic [CountBits-1:0] rsp_samples_held;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [15:0]          csr_data = '0;
   req_word_type         req_cur = '0;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int           outstanding = 0;
   int           fail_count = 0;
   int           gap_max = 10;
   int unsigned  req_gap = 0;
   int unsigned  rsp_stall = 0;

   // Shadow of the engine used to predict every response word.
   logic [CompBits-1:0] km_samples [SampleDepth][Dims];
   logic [2:0]          km_labels [SampleDepth];
   longint unsigned     km_means [MaxClusters][Dims];
   int unsigned         km_held = 0;
   longint unsigned     km_cost = 0;
   int unsigned         km_rounds = 0;
   int unsigned         cfg_clusters = 2;
   int unsigned         cfg_max_iter = 1000;
   int unsigned         cfg_tolerance = 7;

   // Stimulus-side bookkeeping: how many samples are held and which were labelled.
   int unsigned gen_held = 0;
   int unsigned gen_items = 0;
   bit          gen_labelled [SampleDepth];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wire [1:0]          req_action_w;
   wire [CompBits-1:0] req_comp0_w, req_comp1_w, req_comp2_w;
   wire [AddrBits-1:0] req_index_w;
   assign {
      req_action_w, req_comp0_w, req_comp1_w, req_comp2_w, req_index_w
   } = req_cur;

   kmeans_clustering_engine_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action_w),
      .req_comp0        (req_comp0_w),
      .req_comp1        (req_comp1_w),
      .req_comp2        (req_comp2_w),
      .req_sample_index (req_index_w),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_label        (rsp_label),
      .rsp_rounds_done  (rsp_rounds_done),
      .rsp_average_cost (rsp_average_cost),
      .rsp_samples_held (rsp_samples_held),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   function automatic int unsigned clamp_clusters(int unsigned raw);
      int unsigned k;
      k = raw & 15;
      if (k == 0) k = 1;
      if (k > MaxClusters) k = MaxClusters;
      return k;
   endfunction

   // Integer square root, floor.
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Closest mean by squared distance; the lowest index wins a tie.
   function automatic int unsigned nearest_mean(int unsigned s, int unsigned k,
                                                output longint unsigned best_sq);
      longint unsigned sq, a, b, df;
      int unsigned     best;
      best = 0;
      best_sq = 0;
      for (int unsigned c = 0; c < k; c++) begin
         sq = 0;
         for (int d = 0; d < Dims; d++) begin
            a = 64'(km_samples[s][d]);
            a = a << 8;
            b = km_means[c][d];
            df = (a >= b) ? a - b : b - a;
            sq += df * df;
         end
         if (c == 0 || sq < best_sq) begin
            best_sq = sq;
            best = c;
         end
      end
      return best;
   endfunction

   // Lloyd rounds followed by labelling of every held sample.
   function automatic kmce_status_type run_lloyd();
      int unsigned     k, n, spacing, stable, c;
      longint unsigned last, curr, total, sq, df, a;
      longint unsigned sums [MaxClusters][Dims];
      int unsigned     counts [MaxClusters];
      k = clamp_clusters(cfg_clusters);
      n = km_held;
      if (n < k) return ST_FEW;
      spacing = n / k;
      for (int unsigned i = 0; i < k; i++)
         for (int d = 0; d < Dims; d++) begin
            a = 64'(km_samples[spacing * i][d]);
            km_means[i][d] = a << 8;
         end
      stable = 0;
      km_rounds = 0;
      curr = 0;
      while (1) begin
         last = curr;
         total = 0;
         for (int i = 0; i < MaxClusters; i++) begin
            counts[i] = 0;
            for (int d = 0; d < Dims; d++) sums[i][d] = 0;
         end
         for (int unsigned i = 0; i < n; i++) begin
            c = nearest_mean(i, k, sq);
            total += floor_root(sq);
            counts[c]++;
            for (int d = 0; d < Dims; d++) sums[c][d] += 64'(km_samples[i][d]);
         end
         curr = total / n;
         // An empty cluster keeps its mean.
         for (int unsigned i = 0; i < k; i++)
            if (counts[i] != 0)
               for (int d = 0; d < Dims; d++)
                  km_means[i][d] = ((sums[i][d] << 8) / counts[i]) & 64'hFFFF_FFFF;
         km_rounds = (km_rounds + 1) & 16'hFFFF;
         df = (last >= curr) ? last - curr : curr - last;
         if (df * 65536 < 64'(cfg_tolerance) * last) stable++;
         if (km_rounds >= cfg_max_iter || stable >= 3) break;
      end
      km_cost = curr;
      for (int unsigned i = 0; i < n; i++) km_labels[i] = 3'(nearest_mean(i, k, sq));
      return ST_OK;
   endfunction

   function automatic rsp_word_type predict_response(req_word_type w);
      rsp_word_type r;
      r.status = ST_OK;
      r.label = '0;
      case (w.action)
         ACT_LOAD: begin
            if (km_held >= SampleDepth) begin
               r.status = ST_FULL;
            end else begin
               km_samples[km_held][0] = w.comp0;
               km_samples[km_held][1] = w.comp1;
               km_samples[km_held][2] = w.comp2;
               km_held++;
            end
         end
         ACT_RUN: r.status = run_lloyd();
         ACT_READ: begin
            if (w.index < km_held) r.label = km_labels[w.index];
            else r.status = ST_RANGE;
         end
         default: km_held = 0;
      endcase
      r.rounds = km_rounds[15:0];
      r.cost = km_cost[CostBits-1:0];
      r.held = km_held[CountBits-1:0];
      return r;
   endfunction

   // Request driver: one word at a time from the pending queue, random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsp.push_back(predict_response(req_cur));
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_cur <= pending_words.pop_front();
               req_valid <= 1'b1;
               outstanding++;
               req_gap <= $urandom_range(0, gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin
      rsp_word_type got, want;
      int unsigned  st;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {kmce_status_type'(rsp_status), rsp_label, rsp_rounds_done,
                   rsp_average_cost, rsp_samples_held};
            outstanding--;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected response word status=%0d", rsp_status);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status || got.label !== want.label ||
                   got.rounds !== want.rounds || got.cost !== want.cost ||
                   got.held !== want.held) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"ERROR: status %0d/%0d label %0d/%0d rounds %0d/%0d ",
                               "cost %0d/%0d held %0d/%0d (expected/actual)"},
                              want.status, got.status, want.label, got.label,
                              want.rounds, got.rounds, want.cost, got.cost,
                              want.held, got.held);
               end
            end
            st = $urandom_range(0, gap_max);
            rsp_stall <= st;
            rsp_ready <= (st == 0);
         end else if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= (rsp_stall == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_word(kmce_action_type act, logic [7:0] c0, logic [7:0] c1,
                            logic [7:0] c2, logic [11:0] idx);
      req_word_type w;
      w = {act, c0, c1, c2, idx};
      pending_words.push_back(w);
      gen_items++;
      case (act)
         ACT_LOAD: if (gen_held < SampleDepth) gen_held++;
         ACT_RUN:
            if (gen_held >= clamp_clusters(cfg_clusters))
               for (int unsigned i = 0; i < gen_held; i++) gen_labelled[i] = 1'b1;
         ACT_CLEAR: gen_held = 0;
         default: ;
      endcase
   endtask

   task automatic push_load(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      push_word(ACT_LOAD, c0, c1, c2, 12'($urandom));
   endtask

   task automatic push_random_load();
      push_load(8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // A read either hits a labelled sample or lands beyond the held count.
   task automatic push_read();
      int unsigned i;
      if (gen_held > 0 && $urandom_range(0, 2) != 0) begin
         i = $urandom_range(0, gen_held - 1);
         if (gen_labelled[i]) begin
            push_word(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), i[11:0]);
            return;
         end
      end
      if (gen_held < SampleDepth) begin
         i = $urandom_range(gen_held, SampleDepth - 1);
         push_word(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), i[11:0]);
      end
   endtask

   task automatic push_run();
      push_word(ACT_RUN, 8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom));
   endtask

   task automatic push_clear();
      push_word(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom));
   endtask

   // Wait until every queued word has been answered.
   task automatic drain();
      while (pending_words.size() != 0 || outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(kmce_csr_type idx, logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_CLUSTERS:  cfg_clusters = 32'(value & 16'hF);
         CSR_MAX_ITER:  cfg_max_iter = 32'(value);
         CSR_TOLERANCE: cfg_tolerance = 32'(value);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One clustering job: clear (mostly), load mostly grouped samples, run, read a few labels.
   task automatic run_episode();
      int unsigned k, m;
      logic [7:0]  base [3][3];
      int unsigned g;
      k = clamp_clusters(cfg_clusters);
      if ($urandom_range(0, 7) != 0 || gen_held > 20) push_clear();
      m = $urandom_range(k, 2 * k + 6);
      for (int i = 0; i < 3; i++)
         for (int d = 0; d < 3; d++) base[i][d] = 8'($urandom);
      for (int unsigned i = 0; i < m; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            push_random_load();
         end else begin
            g = $urandom_range(0, 2);
            push_load(base[g][0] ^ 8'($urandom_range(0, 7)),
                      base[g][1] ^ 8'($urandom_range(0, 7)),
                      base[g][2] ^ 8'($urandom_range(0, 7)));
         end
      end
      push_run();
      repeat ($urandom_range(2, 5)) push_read();
   endtask

   // Stray words: any action in any order.
   task automatic push_noise();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0: push_random_load();
            1: if (gen_held < 24) push_run();
            2: push_read();
            default: push_clear();
         endcase
      end
   endtask

   initial begin
      int unsigned pick;
      for (int i = 0; i < SampleDepth; i++) gen_labelled[i] = 1'b0;
      for (int i = 0; i < MaxClusters; i++)
         for (int d = 0; d < Dims; d++) km_means[i][d] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: empty store, then extreme components at the default settings.
      push_read();
      push_run();
      push_clear();
      push_load(8'h00, 8'h00, 8'h00);
      push_load(8'hFF, 8'hFF, 8'hFF);
      push_load(8'h00, 8'hFF, 8'h00);
      push_load(8'hFF, 8'h00, 8'hFF);
      push_run();
      for (int i = 0; i < 5; i++) push_word(ACT_READ, 8'h00, 8'h00, 8'h00, i[11:0]);
      push_word(ACT_READ, 8'hFF, 8'hFF, 8'hFF, 12'hFFF);

      // Cluster count of zero acts as one, above the maximum as the maximum.
      write_csr(CSR_CLUSTERS, 16'h0000);
      push_run();
      push_read();
      write_csr(CSR_CLUSTERS, 16'hFFFF);
      push_run();
      repeat (4) push_random_load();
      push_run();
      push_word(ACT_READ, 8'h00, 8'h00, 8'h00, 12'd7);

      // Zero iterations still run one round.
      write_csr(CSR_MAX_ITER, 16'h0000);
      write_csr(CSR_CLUSTERS, 16'd3);
      push_run();
      push_read();

      // Largest iteration limit, ended by the stability rule.
      write_csr(CSR_MAX_ITER, 16'hFFFF);
      write_csr(CSR_TOLERANCE, 16'hFFFF);
      push_clear();
      repeat (10) push_random_load();
      push_run();
      push_read();

      // Zero tolerance never counts a stable round.
      write_csr(CSR_TOLERANCE, 16'h0000);
      write_csr(CSR_MAX_ITER, 16'd5);
      write_csr(CSR_UNUSED, 16'h5A5A);
      push_run();
      push_read();

      // Fill the store, then one load too many.
      drain();
      gap_max = 0;
      push_clear();
      repeat (SampleDepth + 1) push_random_load();
      push_read();
      push_clear();
      drain();

      // Random phases with fresh settings each time.
      while (gen_items < 1650 + SampleDepth + 40) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) write_csr(CSR_CLUSTERS, 16'($urandom_range(9, 15)));
         else if (pick == 1) write_csr(CSR_CLUSTERS, 16'h0);
         else write_csr(CSR_CLUSTERS, 16'($urandom_range(1, MaxClusters)));
         write_csr(CSR_MAX_ITER, 16'($urandom_range(0, 16)));
         pick = $urandom_range(0, 4);
         write_csr(CSR_TOLERANCE, pick == 0 ? 16'h0 : pick == 1 ? 16'hFFFF :
                                  pick == 2 ? 16'd7 : 16'($urandom));
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         repeat (4) begin
            if ($urandom_range(0, 9) == 0) push_noise();
            else run_episode();
            if ($urandom_range(0, 5) == 0) drain();
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
